FILE: hdl/ed_pkg.sv
// Shared types and constants for the edit distance engine.
package ed_pkg;

    localparam int MODE_W = 2;
    localparam int SYM_W  = 8;
    localparam int OUT_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND_A = 2'd0,
        MODE_APPEND_B = 2'd1,
        MODE_COMPUTE  = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

endpackage

FILE: hdl/ed_str_mem.sv
// Byte string store: one write port, one read port with registered read data.
module ed_str_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [ed_pkg::SYM_W-1:0] wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [ed_pkg::SYM_W-1:0] rdata
);
    import ed_pkg::*;

    logic [SYM_W-1:0] mem [DEPTH];
    logic [SYM_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/edit_distance_engine.sv
// Levenshtein edit distance engine: byte strings A and B, one DP row in memory.
//
// Each input beat either appends s_symbol to string A (mode 0), appends it to
// string B (mode 1), or starts a distance computation (mode 2); mode 3 is
// ignored. A string holds MAX_LEN bytes; bytes beyond that are dropped and
// the sticky truncated flag is set. A compute beat returns one result beat
// with the unit-cost edit distance, both string lengths and the truncated
// flag, then empties both strings and clears the flag. The recurrence runs
// one DP cell per cycle within a row out of a single-row memory of MAX_LEN+1
// entries: for lengths la and lb (both nonzero) a compute first seeds the
// row, then per row fetches the A byte and updates each cell, the cell rate
// being set by the read/modify/write loop on the row memory. If either
// string is empty the seeding and row passes are skipped. Input is taken
// only while the engine is idle; a finished result waits in the output
// register, and new appends are taken while it waits. Result fields are
// masked to 7 bits.
module edit_distance_engine #(
    parameter int MAX_LEN = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ed_pkg::MODE_W-1:0] s_mode,
    input  logic [ed_pkg::SYM_W-1:0]  s_symbol,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ed_pkg::OUT_W-1:0]  m_distance,
    output logic [ed_pkg::OUT_W-1:0]  m_length_a_out,
    output logic [ed_pkg::OUT_W-1:0]  m_length_b_out,
    output logic                      m_truncated
);
    import ed_pkg::*;

    // lengths and DP values run 0..MAX_LEN; DP row addresses 0..MAX_LEN
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_START,
        ST_ROW,
        ST_FINISH
    } state_t;

    state_t           state_reg;
    logic [LEN_W-1:0] len_a_reg;
    logic [LEN_W-1:0] len_b_reg;
    logic             ovf_reg;
    logic [LEN_W-1:0] i_reg;        // current row (index into A, from 1)
    logic [LEN_W-1:0] j_reg;        // column being fetched / seeded
    logic             issuing_reg;  // more columns to fetch in this row
    logic             rd_valid_reg; // fetched column data is in the read regs
    logic [LEN_W-1:0] rd_j_reg;     // column of that data
    logic [LEN_W-1:0] left_reg;     // dp[j-1] of the current row
    logic [LEN_W-1:0] diag_reg;     // dp[j-1] of the previous row
    logic [LEN_W-1:0] dist_reg;

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_dist_reg;
    logic [OUT_W-1:0] m_la_reg;
    logic [OUT_W-1:0] m_lb_reg;
    logic             m_trunc_reg;

    // DP row memory
    logic [LEN_W-1:0] dp_mem [MAX_LEN + 1];
    logic [LEN_W-1:0] dp_q_reg;
    logic             dp_we;
    logic [LEN_W-1:0] dp_waddr;
    logic [LEN_W-1:0] dp_wdata;
    logic             dp_re;

    // string stores
    logic             a_we;
    logic             b_we;
    logic             a_re;
    logic [LEN_W-1:0] i_m1;
    logic [LEN_W-1:0] j_m1;
    logic [SYM_W-1:0] a_q;
    logic [SYM_W-1:0] b_q;

    logic             accept;
    logic             a_full;
    logic             b_full;
    logic [LEN_W-1:0] min_ul;
    logic [LEN_W-1:0] min_all;
    logic [LEN_W-1:0] cell_val;
    logic [31:0]      dist_ext;
    logic [31:0]      la_ext;
    logic [31:0]      lb_ext;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign a_full  = (len_a_reg == LEN_FULL);
    assign b_full  = (len_b_reg == LEN_FULL);

    assign a_we = accept && (s_mode == MODE_APPEND_A) && !a_full;
    assign b_we = accept && (s_mode == MODE_APPEND_B) && !b_full;
    assign a_re = (state_reg == ST_ROW_START);
    assign i_m1 = i_reg - LEN_ONE;
    assign j_m1 = j_reg - LEN_ONE;

    // B byte and dp[j] are fetched together, one column per cycle
    assign dp_re = (state_reg == ST_ROW_START) || ((state_reg == ST_ROW) && issuing_reg);

    ed_str_mem #(
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W)
    ) u_str_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (len_a_reg[ADDR_W-1:0]),
        .wdata (s_symbol),
        .re    (a_re),
        .raddr (i_m1[ADDR_W-1:0]),
        .rdata (a_q)
    );

    ed_str_mem #(
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W)
    ) u_str_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (len_b_reg[ADDR_W-1:0]),
        .wdata (s_symbol),
        .re    (dp_re),
        .raddr (j_m1[ADDR_W-1:0]),
        .rdata (b_q)
    );

    // cell update: match takes the diagonal, else 1 + min(up, left, diag)
    assign min_ul   = (dp_q_reg < left_reg) ? dp_q_reg : left_reg;
    assign min_all  = (min_ul < diag_reg) ? min_ul : diag_reg;
    assign cell_val = (a_q == b_q) ? diag_reg : (min_all + LEN_ONE);

    always_comb begin
        dp_we    = 1'b0;
        dp_waddr = j_reg;
        dp_wdata = j_reg;
        case (state_reg)
            ST_INIT: begin
                dp_we = 1'b1;
            end
            ST_ROW: begin
                dp_we    = rd_valid_reg;
                dp_waddr = rd_j_reg;
                dp_wdata = cell_val;
            end
            default: begin
                dp_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (dp_we) begin
            dp_mem[dp_waddr] <= dp_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_re) begin
            dp_q_reg <= dp_mem[j_reg];
        end
    end

    // mask result fields to the 7-bit ports
    assign dist_ext = 32'(dist_reg);
    assign la_ext   = 32'(len_a_reg);
    assign lb_ext   = 32'(len_b_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_a_reg    <= '0;
            len_b_reg    <= '0;
            ovf_reg      <= 1'b0;
            issuing_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // ST_FINISH handles the output register itself
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_mode)
                            MODE_APPEND_A: begin
                                if (a_full) begin
                                    ovf_reg <= 1'b1;
                                end else begin
                                    len_a_reg <= len_a_reg + LEN_ONE;
                                end
                            end
                            MODE_APPEND_B: begin
                                if (b_full) begin
                                    ovf_reg <= 1'b1;
                                end else begin
                                    len_b_reg <= len_b_reg + LEN_ONE;
                                end
                            end
                            MODE_COMPUTE: begin
                                if ((len_a_reg == '0) || (len_b_reg == '0)) begin
                                    // one side empty: distance is the other length
                                    dist_reg  <= len_a_reg | len_b_reg;
                                    state_reg <= ST_FINISH;
                                end else begin
                                    j_reg     <= LEN_ONE;
                                    state_reg <= ST_INIT;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_INIT: begin
                    // seed dp[j] = j for j = 1..lb; dp[0] is implied by the row index
                    if (j_reg == len_b_reg) begin
                        i_reg     <= LEN_ONE;
                        j_reg     <= LEN_ONE;
                        state_reg <= ST_ROW_START;
                    end else begin
                        j_reg <= j_reg + LEN_ONE;
                    end
                end
                ST_ROW_START: begin
                    // fetch A[i-1] and column 1 of the row
                    diag_reg     <= i_m1;
                    left_reg     <= i_reg;
                    rd_valid_reg <= 1'b1;
                    rd_j_reg     <= j_reg;
                    if (len_b_reg == LEN_ONE) begin
                        issuing_reg <= 1'b0;
                    end else begin
                        issuing_reg <= 1'b1;
                        j_reg       <= j_reg + LEN_ONE;
                    end
                    state_reg <= ST_ROW;
                end
                ST_ROW: begin
                    rd_valid_reg <= issuing_reg;
                    rd_j_reg     <= j_reg;
                    if (issuing_reg) begin
                        if (j_reg == len_b_reg) begin
                            issuing_reg <= 1'b0;
                        end else begin
                            j_reg <= j_reg + LEN_ONE;
                        end
                    end
                    if (rd_valid_reg) begin
                        left_reg <= cell_val;
                        diag_reg <= dp_q_reg;
                        if (rd_j_reg == len_b_reg) begin
                            if (i_reg == len_a_reg) begin
                                dist_reg  <= cell_val;
                                state_reg <= ST_FINISH;
                            end else begin
                                i_reg     <= i_reg + LEN_ONE;
                                j_reg     <= LEN_ONE;
                                state_reg <= ST_ROW_START;
                            end
                        end
                    end
                end
                ST_FINISH: begin
                    // hand off to the output register, then empty both strings
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_dist_reg  <= dist_ext[OUT_W-1:0];
                        m_la_reg    <= la_ext[OUT_W-1:0];
                        m_lb_reg    <= lb_ext[OUT_W-1:0];
                        m_trunc_reg <= ovf_reg;
                        len_a_reg   <= '0;
                        len_b_reg   <= '0;
                        ovf_reg     <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_distance     = m_dist_reg;
    assign m_length_a_out = m_la_reg;
    assign m_length_b_out = m_lb_reg;
    assign m_truncated    = m_trunc_reg;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the Levenshtein edit distance engine.
module tb_top;
    import ed_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int CYCLE_LIMIT  = 800000;
    // Longest compute, with both strings full, plus margin.
    localparam int SETTLE_CYCLES = 2 + MAX_LEN + MAX_LEN * (MAX_LEN + 1) + 100;
    localparam int RANDOM_BEATS = 1000;
    localparam int HOLD_CYCLES  = 600;

    typedef struct packed {
        logic [OUT_W-1:0] distance;
        logic [OUT_W-1:0] length_a;
        logic [OUT_W-1:0] length_b;
        logic             truncated;
    } distance_result_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [MODE_W-1:0] s_mode;
    logic [SYM_W-1:0] s_symbol;
    logic             m_valid;
    logic             m_ready;
    logic [OUT_W-1:0] m_distance;
    logic [OUT_W-1:0] m_length_a_out;
    logic [OUT_W-1:0] m_length_b_out;
    logic             m_truncated;

    // Shadow copy of the engine state, updated on every accepted input beat.
    logic [SYM_W-1:0] shadow_a [MAX_LEN];
    logic [SYM_W-1:0] shadow_b [MAX_LEN];
    int               shadow_len_a;
    int               shadow_len_b;
    bit               shadow_dropped;

    distance_result_t pending_results [$];

    int mismatch_count;
    int beats_sent;
    int results_seen;
    int truncated_seen;
    int cycle_count;
    int burst_left;
    int hold_req_count;

    always #5 aclk = ~aclk;

    edit_distance_engine #(
        .MAX_LEN(MAX_LEN)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_symbol       (s_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_distance     (m_distance),
        .m_length_a_out (m_length_a_out),
        .m_length_b_out (m_length_b_out),
        .m_truncated    (m_truncated)
    );

    // Unit-cost edit distance over the shadow strings, single DP row.
    function automatic int shadow_edit_distance(input int len_a, input int len_b);
        int row [MAX_LEN+1];
        int diag;
        int up;
        int best;
        for (int j = 0; j <= len_b; j++) row[j] = j;
        for (int i = 1; i <= len_a; i++) begin
            diag   = row[0];
            row[0] = i;
            for (int j = 1; j <= len_b; j++) begin
                up = row[j];
                if (shadow_a[i-1] == shadow_b[j-1]) begin
                    row[j] = diag;
                end else begin
                    best = (up < row[j-1]) ? up : row[j-1];
                    best = (best < diag) ? best : diag;
                    row[j] = best + 1;
                end
                diag = up;
            end
        end
        return row[len_b];
    endfunction

    task automatic shadow_accept(input mode_t mode, input logic [SYM_W-1:0] sym);
        distance_result_t res;
        int               dist_val;
        case (mode)
            MODE_APPEND_A: begin
                if (shadow_len_a < MAX_LEN) begin
                    shadow_a[shadow_len_a] = sym;
                    shadow_len_a++;
                end else begin
                    shadow_dropped = 1'b1;
                end
            end
            MODE_APPEND_B: begin
                if (shadow_len_b < MAX_LEN) begin
                    shadow_b[shadow_len_b] = sym;
                    shadow_len_b++;
                end else begin
                    shadow_dropped = 1'b1;
                end
            end
            MODE_COMPUTE: begin
                dist_val      = shadow_edit_distance(shadow_len_a, shadow_len_b);
                res.distance  = dist_val[OUT_W-1:0];
                res.length_a  = shadow_len_a[OUT_W-1:0];
                res.length_b  = shadow_len_b[OUT_W-1:0];
                res.truncated = shadow_dropped;
                pending_results = {pending_results, res};
                shadow_len_a   = 0;
                shadow_len_b   = 0;
                shadow_dropped = 1'b0;
            end
            default: begin
                // unused mode: ignored by the engine
            end
        endcase
    endtask

    // Offer one input beat; returns in the time step of the accepting edge with
    // valid still high, so back-to-back beats never toggle valid.
    task automatic send_beat(input mode_t mode, input logic [SYM_W-1:0] sym);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_symbol <= sym;
        do @(posedge aclk); while (s_ready !== 1'b1);
        shadow_accept(mode, sym);
        if (mode != MODE_UNUSED) beats_sent++;
    endtask

    task automatic send_word(input mode_t mode, input string word);
        for (int k = 0; k < word.len(); k++) send_beat(mode, word[k]);
    endtask

    // Sender pause: drop valid and wait until every predicted result is back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // One string pair with random interleaving of A and B beats, then compute.
    task automatic send_pair(input int len_a, input int len_b, input int alphabet,
                             input bit similar);
        logic [SYM_W-1:0] a_bytes [80];
        logic [SYM_W-1:0] b_bytes [80];
        logic [SYM_W-1:0] base;
        int               ia;
        int               ib;
        base = SYM_W'($urandom_range(0, 255));
        for (ia = 0; ia < len_a; ia++)
            a_bytes[ia] = base + SYM_W'($urandom_range(0, alphabet - 1));
        for (ib = 0; ib < len_b; ib++) begin
            if (similar && ib < len_a && $urandom_range(0, 3) != 0)
                b_bytes[ib] = a_bytes[ib];
            else
                b_bytes[ib] = base + SYM_W'($urandom_range(0, alphabet - 1));
        end
        ia = 0;
        ib = 0;
        while (ia < len_a || ib < len_b) begin
            if ($urandom_range(0, 29) == 0)
                send_beat(MODE_UNUSED, SYM_W'($urandom_range(0, 255)));
            if (ib >= len_b || (ia < len_a && $urandom_range(0, 1) == 1)) begin
                send_beat(MODE_APPEND_A, a_bytes[ia]);
                ia++;
            end else begin
                send_beat(MODE_APPEND_B, b_bytes[ib]);
                ib++;
            end
        end
        send_beat(MODE_COMPUTE, SYM_W'($urandom_range(0, 255)));
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: check each accepted beat, then drive ready on a shifting
    // stall pattern, with a long hold-off when a test asks for one.
    always @(posedge aclk) begin : result_monitor
        distance_result_t want;
        int               hold_left;
        int               hold_ack;
        int               stall_pct;
        int               phase_left;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: distance %0d", m_distance);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("distance", want.distance, m_distance);
                check_field("length_a_out", want.length_a, m_length_a_out);
                check_field("length_b_out", want.length_b, m_length_b_out);
                check_field("truncated", OUT_W'(want.truncated), OUT_W'(m_truncated));
                results_seen++;
                if (want.truncated) truncated_seen++;
            end
        end
        if (hold_req_count != hold_ack) begin
            hold_left = HOLD_CYCLES;
            hold_ack  = hold_req_count;
        end
        if (phase_left <= 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            phase_left = $urandom_range(50, 300);
        end else begin
            phase_left--;
        end
        if (aresetn !== 1'b1) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at the cycle limit, %0d results pending",
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Empty strings, field extremes, unused mode and a textbook pair.
    task automatic test_directed();
        send_beat(MODE_COMPUTE, 8'hFF);
        send_beat(MODE_APPEND_A, 8'h00);
        send_beat(MODE_APPEND_A, 8'hFF);
        send_beat(MODE_COMPUTE, 8'h00);
        send_beat(MODE_UNUSED, 8'hFF);
        send_word(MODE_APPEND_B, "abc");
        send_beat(MODE_UNUSED, 8'h00);
        send_beat(MODE_COMPUTE, 8'h55);
        send_beat(MODE_APPEND_A, 8'hA5);
        send_beat(MODE_APPEND_B, 8'hA5);
        send_beat(MODE_COMPUTE, 8'hAA);
        send_word(MODE_APPEND_A, "kitten");
        send_word(MODE_APPEND_B, "sitting");
        send_beat(MODE_COMPUTE, 8'h00);
        wait_for_results();
    endtask

    // Full strings: extra bytes dropped, lengths held at capacity, flag sticky.
    task automatic test_saturation();
        for (int k = 0; k < MAX_LEN + 2; k++) send_beat(MODE_APPEND_A, SYM_W'(k));
        for (int k = 0; k < MAX_LEN; k++) send_beat(MODE_APPEND_B, SYM_W'(k + 1));
        send_beat(MODE_COMPUTE, 8'h00);
        for (int k = 0; k < MAX_LEN + 1; k++)
            send_beat(MODE_APPEND_B, SYM_W'($urandom_range(0, 255)));
        send_beat(MODE_COMPUTE, 8'h00);
        // flag must be clear again after the compute
        send_beat(MODE_APPEND_A, 8'h7F);
        send_beat(MODE_COMPUTE, 8'h00);
        wait_for_results();
    endtask

    // Receiver held off while results pile up: the engine must stall input.
    task automatic test_backpressure();
        hold_req_count++;
        send_pair(6, 6, 4, 1'b1);
        send_pair(4, 4, 256, 1'b0);
        send_pair(3, 3, 2, 1'b0);
        send_pair(2, 0, 2, 1'b0);
        send_beat(MODE_COMPUTE, 8'h00);
        wait_for_results();
    endtask

    task automatic test_random_pairs();
        int goal;
        int kind;
        goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
                send_pair($urandom_range(0, 8), $urandom_range(0, 8),
                          $urandom_range(2, 4), $urandom_range(0, 1));
            else if (kind < 80)
                send_pair($urandom_range(0, 20), $urandom_range(0, 20),
                          ($urandom_range(0, 1) == 1) ? 256 : 3, $urandom_range(0, 1));
            else if (kind < 88)
                send_pair($urandom_range(0, 12), 0, 256, 1'b0);
            else if (kind < 92)
                send_pair(0, $urandom_range(0, 12), 256, 1'b0);
            else if (kind < 95)
                repeat ($urandom_range(1, 4))
                    send_beat(MODE_UNUSED, SYM_W'($urandom_range(0, 255)));
            else if (kind < 98)
                send_beat(MODE_COMPUTE, SYM_W'($urandom_range(0, 255)));
            else
                send_pair($urandom_range(56, 70), $urandom_range(56, 70),
                          $urandom_range(2, 256), $urandom_range(0, 1));
        end
    endtask

    task automatic test_finish();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            mismatch_count++;
        end
        $display("Sent %0d input beats and checked %0d distance results (%0d truncated),",
                 beats_sent, results_seen, truncated_seen);
        $display("covering empty and full strings, unused mode and output backpressure.");
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_mode         = MODE_APPEND_A;
        s_symbol       = '0;
        shadow_len_a   = 0;
        shadow_len_b   = 0;
        shadow_dropped = 1'b0;
        mismatch_count = 0;
        beats_sent     = 0;
        results_seen   = 0;
        truncated_seen = 0;
        burst_left     = 0;
        hold_req_count = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_saturation();
        test_backpressure();
        test_random_pairs();
        test_finish();
    end

endmodule
